FILE: src/pipelined_reply_reorder_buffer_defines.svh
// assertion macros for the reply reorder buffer checker
// expects clk and arst_n in the scope of use
`ifndef PIPELINED_REPLY_REORDER_BUFFER_DEFINES_SVH
`define PIPELINED_REPLY_REORDER_BUFFER_DEFINES_SVH
// checked out of reset only
`define PRRB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define PRRB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: src/prrb_pkg.sv
// types and constants of the reply reorder buffer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package prrb_pkg;
	localparam logic [1:0] ACT_REQUEST = 2'd0;
	localparam logic [1:0] ACT_REPLY = 2'd1;
	localparam logic [1:0] ACT_MARK = 2'd2;
	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_STORE_FULL = 2'd1;
	localparam logic [1:0] ERR_FIFO_FULL = 2'd2;
	localparam logic [9:0] CLOSE_STATUS = 10'd500;
	localparam int REL_CW = 5;
	localparam logic [REL_CW-1:0] MAX_RESULTS = 5'd16;

	typedef struct packed {
		logic [1:0] action;
		logic [31:0] request_id;
		logic reply_final;
		logic [9:0] reply_status;
		logic [15:0] reply_tag;
	} req_t;

	typedef struct packed {
		logic released;
		logic [31:0] released_id;
		logic [15:0] released_tag;
		logic released_final;
		logic closing;
		logic [1:0] error_code;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] id;
		logic fin;
		logic [15:0] tag;
	} entry_t;
endpackage
`default_nettype wire

FILE: src/pipelined_reply_reorder_buffer.sv
// Reply reorder buffer: takes one item at a time and returns one or more result transfers;
// the input stalls from the accepted transfer until the item's last result is registered.
// A request, mark or unknown item returns one status result. A reply item is inserted by
// reading and comparing the stored replies from the tail down, one read and one compare per
// entry, moving each one with a higher id up one place, and then releases matching stored
// replies (at most 16); a reply on a full store is dropped and the release pass still runs.
// No clearing pass after reset.
// depends on prrb_pkg
`timescale 1ns / 1ps
`default_nettype none
module pipelined_reply_reorder_buffer import prrb_pkg::*; #(
	parameter int REPLY_DEPTH = 16,
	parameter int PENDING_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output rsp_t rsp
);
	localparam int RW = $clog2(REPLY_DEPTH);
	localparam int PW = $clog2(PENDING_DEPTH);
	localparam int RCW = $clog2(REPLY_DEPTH + 1);
	localparam int PCW = $clog2(PENDING_DEPTH + 1);

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_EXEC = 8'b00000010,
		S_STAT = 8'b00000100,
		S_INS_RD = 8'b00001000,
		S_INS_CMP = 8'b00010000,
		S_PUT = 8'b00100000,
		S_REL_RD = 8'b01000000,
		S_REL_CMP = 8'b10000000
	} state_t;

	function automatic logic [RW-1:0] rwrap(input logic [RW-1:0] base, input logic [RW-1:0] off);
		logic [RW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (RW+1)'(REPLY_DEPTH)) s = s - (RW+1)'(REPLY_DEPTH);
		return s[RW-1:0];
	endfunction

	function automatic logic [PW-1:0] pwrap(input logic [PW-1:0] base, input logic [PW-1:0] off);
		logic [PW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (PW+1)'(PENDING_DEPTH)) s = s - (PW+1)'(PENDING_DEPTH);
		return s[PW-1:0];
	endfunction

	state_t state_q;
	req_t item_q;
	logic [1:0] err_q;
	logic closing_q, mark_valid_q;
	logic [31:0] mark_id_q;
	logic [RW-1:0] rhead_q, j_q, pos_q;
	logic [RCW-1:0] rcount_q;
	logic [PW-1:0] phead_q;
	logic [PCW-1:0] pcount_q;
	logic [REL_CW-1:0] n_q;
	entry_t hold_q;
	logic hold_v_q;
	rsp_t out_q;
	logic out_v_q;

	entry_t rmem [REPLY_DEPTH];
	logic [31:0] pmem [PENDING_DEPTH];
	entry_t rrd_q;
	logic [31:0] prd_q;

	logic r_we, r_re, p_we, p_re;
	logic [RW-1:0] r_waddr, r_raddr;
	entry_t r_wdata, new_entry;
	logic [PW-1:0] p_waddr;
	logic can_emit, emit, match, advance;
	rsp_t emit_d;

	assign new_entry = '{id: item_q.request_id, fin: item_q.reply_final, tag: item_q.reply_tag};
	assign can_emit = !out_v_q || !rsp_stall;
	assign match = (rcount_q != '0) && (pcount_q != '0) && (n_q != MAX_RESULTS)
		&& (rrd_q.id == prd_q);

	always_comb begin
		r_we = 1'b0;
		r_re = 1'b0;
		r_waddr = rwrap(rhead_q, pos_q);
		r_raddr = rhead_q;
		r_wdata = new_entry;
		p_we = 1'b0;
		p_re = 1'b0;
		p_waddr = pwrap(phead_q, pcount_q[PW-1:0]);
		emit = 1'b0;
		advance = 1'b0;
		emit_d = '{released: 1'b0, released_id: '0, released_tag: '0, released_final: 1'b0,
			closing: closing_q, error_code: err_q, last: 1'b1};
		case (state_q)
			S_EXEC: begin
				p_we = (item_q.action == ACT_REQUEST) && (pcount_q != PCW'(PENDING_DEPTH));
			end
			S_STAT: begin
				emit = can_emit;
			end
			S_INS_RD: begin
				r_re = 1'b1;
				r_raddr = rwrap(rhead_q, j_q);
			end
			S_INS_CMP: begin
				if (rrd_q.id > item_q.request_id) begin
					r_we = 1'b1;
					r_waddr = rwrap(rhead_q, j_q + RW'(1));
					r_wdata = rrd_q;
				end
			end
			S_PUT: begin
				r_we = 1'b1;
			end
			S_REL_RD: begin
				r_re = 1'b1;
				p_re = 1'b1;
			end
			S_REL_CMP: begin
				if (hold_v_q) begin
					emit_d.released = 1'b1;
					emit_d.released_id = hold_q.id;
					emit_d.released_tag = hold_q.tag;
					emit_d.released_final = hold_q.fin;
				end
				if (match) begin
					emit_d.last = 1'b0;
					advance = !hold_v_q || can_emit;
					emit = hold_v_q && can_emit;
				end else begin
					emit = can_emit;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (r_we) rmem[r_waddr] <= r_wdata;
		if (r_re) rrd_q <= rmem[r_raddr];
		if (p_we) pmem[p_waddr] <= item_q.request_id;
		if (p_re) prd_q <= pmem[phead_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q <= ERR_OK;
			closing_q <= 1'b0;
			mark_valid_q <= 1'b0;
			rhead_q <= '0;
			rcount_q <= '0;
			phead_q <= '0;
			pcount_q <= '0;
			n_q <= '0;
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
			j_q <= '0;
			pos_q <= '0;
		end else begin
			if (emit) begin
				out_v_q <= 1'b1;
				out_q <= emit_d;
			end else if (out_v_q && !rsp_stall) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						item_q <= req;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					n_q <= '0;
					hold_v_q <= 1'b0;
					case (item_q.action)
						ACT_REQUEST: begin
							state_q <= S_STAT;
							if (pcount_q != PCW'(PENDING_DEPTH)) begin
								pcount_q <= pcount_q + PCW'(1);
								err_q <= ERR_OK;
							end else begin
								err_q <= ERR_FIFO_FULL;
							end
						end
						ACT_MARK: begin
							err_q <= ERR_OK;
							state_q <= S_STAT;
							if (!mark_valid_q) begin
								mark_valid_q <= 1'b1;
								mark_id_q <= item_q.request_id;
							end
						end
						ACT_REPLY: begin
							if ((item_q.reply_status >= CLOSE_STATUS) || (item_q.reply_final
								&& mark_valid_q && mark_id_q == item_q.request_id))
								closing_q <= 1'b1;
							if (rcount_q == RCW'(REPLY_DEPTH)) begin
								err_q <= ERR_STORE_FULL;
								state_q <= S_REL_RD;
							end else if (rcount_q == '0) begin
								err_q <= ERR_OK;
								pos_q <= '0;
								state_q <= S_PUT;
							end else begin
								err_q <= ERR_OK;
								j_q <= RW'(rcount_q - RCW'(1));
								state_q <= S_INS_RD;
							end
						end
						default: begin
							err_q <= ERR_OK;
							state_q <= S_STAT;
						end
					endcase
				end
				S_STAT: begin
					if (can_emit) state_q <= S_IDLE;
				end
				S_INS_RD: begin
					state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if (rrd_q.id > item_q.request_id) begin
						if (j_q == '0) begin
							pos_q <= '0;
							state_q <= S_PUT;
						end else begin
							j_q <= j_q - RW'(1);
							state_q <= S_INS_RD;
						end
					end else begin
						pos_q <= j_q + RW'(1);
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					rcount_q <= rcount_q + RCW'(1);
					state_q <= S_REL_RD;
				end
				S_REL_RD: begin
					state_q <= S_REL_CMP;
				end
				S_REL_CMP: begin
					if (match) begin
						if (advance) begin
							hold_q <= rrd_q;
							hold_v_q <= 1'b1;
							n_q <= n_q + REL_CW'(1);
							rhead_q <= rwrap(rhead_q, RW'(1));
							rcount_q <= rcount_q - RCW'(1);
							if (rrd_q.fin) begin
								phead_q <= pwrap(phead_q, PW'(1));
								pcount_q <= pcount_q - PCW'(1);
							end
							state_q <= S_REL_RD;
						end
					end else if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_v_q;
	assign rsp = out_q;
endmodule
`default_nettype wire

FILE: src/prrb_checker.sv
// port checker for the reply reorder buffer, bound to the top level
// depends on prrb_pkg and pipelined_reply_reorder_buffer_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "pipelined_reply_reorder_buffer_defines.svh"
module prrb_checker import prrb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);
	`PRRB_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled result changed")
	`PRRB_ASSERT(a_status_clean, rsp_valid && !rsp.released |-> rsp.released_id == 32'd0 && rsp.released_tag == 16'd0 && !rsp.released_final, "status-only result carries reply data")
	`PRRB_ASSERT(a_closing_sticky, rsp_valid && !rsp_stall && rsp.closing |=> !rsp_valid || rsp.closing, "closing flag dropped")
	`PRRB_ASSERT(a_req_busy, req_valid && !req_stall |=> req_stall, "input not stalled after a transfer")
	`PRRB_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !rsp_valid, "result during reset")
endmodule

bind pipelined_reply_reorder_buffer prrb_checker u_prrb_checker (.*);
`default_nettype wire

FILE: dv/pipelined_reply_reorder_buffer_tb.sv
// testbench of the reply reorder buffer: directed and random request, reply and mark items
// with a behavioral predictor of the sorted reply store and the outstanding id fifo
// depends on prrb_pkg and pipelined_reply_reorder_buffer
`timescale 1ns / 1ps
module pipelined_reply_reorder_buffer_tb;
	import prrb_pkg::*;

	localparam int STORE_DEPTH = 16;
	localparam int FIFO_DEPTH = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] ACT_UNKNOWN = 2'd3;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	pipelined_reply_reorder_buffer #(
		.REPLY_DEPTH(STORE_DEPTH),
		.PENDING_DEPTH(FIFO_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// predictor state
	entry_t sorted_replies[$];
	logic [31:0] open_ids[$];
	logic close_armed;
	logic [31:0] close_id;
	logic close_sticky;
	rsp_t expected_rsp[$];

	int failures = 0;
	int cycles = 0;
	int burst_left;
	int stall_mode = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void predict_item(input req_t item);
		logic [1:0] err;
		int n;
		int pos;
		entry_t head;
		entry_t released_q[$];
		rsp_t r;
		err = ERR_OK;
		n = 0;
		if (item.action == ACT_REQUEST) begin
			if (open_ids.size() < FIFO_DEPTH)
				open_ids.insert(open_ids.size(), item.request_id);
			else
				err = ERR_FIFO_FULL;
		end else if (item.action == ACT_MARK) begin
			if (!close_armed) begin
				close_armed = 1'b1;
				close_id = item.request_id;
			end
		end else if (item.action == ACT_REPLY) begin
			if (item.reply_status >= CLOSE_STATUS)
				close_sticky = 1'b1;
			if (item.reply_final && close_armed && close_id == item.request_id)
				close_sticky = 1'b1;
			if (sorted_replies.size() >= STORE_DEPTH) begin
				err = ERR_STORE_FULL;
			end else begin
				pos = 0;
				while (pos < sorted_replies.size() && sorted_replies[pos].id <= item.request_id)
					pos++;
				sorted_replies.insert(pos, entry_t'{id: item.request_id,
					fin: item.reply_final, tag: item.reply_tag});
			end
			while (n < 16 && sorted_replies.size() > 0 && open_ids.size() > 0 &&
					sorted_replies[0].id == open_ids[0]) begin
				head = sorted_replies[0];
				sorted_replies.delete(0);
				if (head.fin)
					open_ids.delete(0);
				released_q.insert(released_q.size(), head);
				n++;
			end
		end
		if (n == 0) begin
			r = '0;
			r.closing = close_sticky;
			r.error_code = err;
			r.last = 1'b1;
			expected_rsp.insert(expected_rsp.size(), r);
		end else begin
			for (int k = 0; k < n; k++) begin
				r = '0;
				r.released = 1'b1;
				r.released_id = released_q[k].id;
				r.released_tag = released_q[k].tag;
				r.released_final = released_q[k].fin;
				r.closing = close_sticky;
				r.error_code = err;
				r.last = (k == n - 1);
				expected_rsp.insert(expected_rsp.size(), r);
			end
		end
	endfunction

	// one item, held until accepted, with bursty gaps
	task automatic send_item(input req_t item);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_item(item);
		burst_left--;
	endtask

	function automatic req_t make_item(input logic [1:0] act, input logic [31:0] id,
			input logic fin, input logic [9:0] status, input logic [15:0] tag);
		req_t item;
		item.action = act;
		item.request_id = id;
		item.reply_final = fin;
		item.reply_status = status;
		item.reply_tag = tag;
		return item;
	endfunction

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// checker and stall pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("pipelined_reply_reorder_buffer verification failed");
				$finish;
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$error("unexpected transfer %p", rsp);
					failures++;
				end else begin
					automatic rsp_t e;
					e = expected_rsp[0];
					expected_rsp.delete(0);
					if (rsp.released !== e.released) begin
						$error("released exp %0h got %0h", e.released, rsp.released);
						failures++;
					end
					if (rsp.released_id !== e.released_id) begin
						$error("released_id exp %0h got %0h", e.released_id, rsp.released_id);
						failures++;
					end
					if (rsp.released_tag !== e.released_tag) begin
						$error("released_tag exp %0h got %0h", e.released_tag,
							rsp.released_tag);
						failures++;
					end
					if (rsp.released_final !== e.released_final) begin
						$error("released_final exp %0h got %0h", e.released_final,
							rsp.released_final);
						failures++;
					end
					if (rsp.closing !== e.closing) begin
						$error("closing exp %0h got %0h", e.closing, rsp.closing);
						failures++;
					end
					if (rsp.error_code !== e.error_code) begin
						$error("error_code exp %0h got %0h", e.error_code, rsp.error_code);
						failures++;
					end
					if (rsp.last !== e.last) begin
						$error("last exp %0h got %0h", e.last, rsp.last);
						failures++;
					end
				end
			end
			if (cycles % 500 == 0)
				stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				default: rsp_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	task automatic test_fifo_full();
		for (int i = 0; i < 17; i++)
			send_item(make_item(ACT_REQUEST, (i == 16) ? 32'hffff_ffff : 32'(100 + i), 1'b0,
				10'd0, 16'd0));
		wait_drained();
	endtask

	task automatic test_store_and_release();
		// fill the store while no request is outstanding
		for (int i = 0; i < 16; i++)
			send_item(make_item(ACT_REPLY, 32'd1 + 32'(i % 3), i == 15, 10'd200,
				16'(16'hffff - i)));
		send_item(make_item(ACT_REPLY, 32'd5, 1'b1, 10'd1023, 16'h1234));
		send_item(make_item(ACT_UNKNOWN, 32'hffff_ffff, 1'b1, 10'd999, 16'hffff));
		send_item(make_item(ACT_REQUEST, 32'd1, 1'b0, 10'd0, 16'd0));
		send_item(make_item(ACT_REQUEST, 32'd2, 1'b0, 10'd0, 16'd0));
		send_item(make_item(ACT_REQUEST, 32'd3, 1'b0, 10'd0, 16'd0));
		// dropped on the full store, the release pass still runs
		send_item(make_item(ACT_REPLY, 32'hffff_ffff, 1'b1, 10'd0, 16'h0));
		send_item(make_item(ACT_REPLY, 32'd2, 1'b1, 10'd0, 16'h2));
		send_item(make_item(ACT_REPLY, 32'd3, 1'b1, 10'd0, 16'h3));
		wait_drained();
	endtask

	task automatic test_mark_close();
		send_item(make_item(ACT_REQUEST, 32'd1, 1'b0, 10'd0, 16'd0));
		send_item(make_item(ACT_REQUEST, 32'd2, 1'b0, 10'd0, 16'd0));
		send_item(make_item(ACT_REQUEST, 32'd3, 1'b0, 10'd0, 16'd0));
		send_item(make_item(ACT_MARK, 32'd1, 1'b0, 10'd0, 16'd0));
		send_item(make_item(ACT_MARK, 32'd2, 1'b0, 10'd0, 16'd0));
		send_item(make_item(ACT_REPLY, 32'd2, 1'b1, 10'd499, 16'd7));
		send_item(make_item(ACT_REPLY, 32'd1, 1'b1, 10'd100, 16'd8));
		send_item(make_item(ACT_REPLY, 32'd3, 1'b1, 10'd500, 16'd9));
		wait_drained();
	endtask

	// well-formed request and reply streams in random order, with some noise
	task automatic test_random();
		logic [31:0] next_id;
		int pick;
		int k;
		next_id = 32'd116;
		for (int n = 0; n < 260; n++) begin
			pick = $urandom_range(0, 99);
			if (open_ids.size() == 0 || (pick < 25 && open_ids.size() < FIFO_DEPTH)) begin
				send_item(make_item(ACT_REQUEST, next_id, 1'b0, 10'($urandom),
					16'($urandom)));
				next_id = next_id + 32'($urandom_range(1, 3));
			end else if (sorted_replies.size() >= STORE_DEPTH - 2) begin
				// retire the head so waiting replies can drain
				send_item(make_item(ACT_REPLY, open_ids[0], 1'b1, 10'($urandom_range(0, 499)),
					16'($urandom)));
			end else if (pick < 90) begin
				k = $urandom_range(0, open_ids.size() - 1);
				send_item(make_item(ACT_REPLY, open_ids[k], $urandom_range(0, 2) == 0,
					($urandom_range(0, 19) == 0) ? 10'($urandom_range(500, 1023))
						: 10'($urandom_range(0, 499)), 16'($urandom)));
			end else if (pick < 95) begin
				send_item(make_item(ACT_REPLY, $urandom, 1'($urandom), 10'($urandom),
					16'($urandom)));
			end else begin
				send_item(make_item(($urandom_range(0, 1) == 0) ? ACT_MARK : ACT_UNKNOWN,
					open_ids[0], 1'($urandom), 10'($urandom), 16'($urandom)));
			end
		end
		wait_drained();
	endtask

	initial begin
		clk = 1'b0;
		burst_left = 0;
		close_armed = 1'b0;
		close_id = '0;
		close_sticky = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_mark_close();
		test_store_and_release();
		test_fifo_full();
		test_random();
		if (failures == 0)
			$display("pipelined_reply_reorder_buffer verification clean");
		else
			$display("pipelined_reply_reorder_buffer verification failed");
		$finish;
	end
endmodule
